@@ design/srfp_pkg.sv @@
package srfp_pkg;

  // Build-time constants
  localparam int MAX_CHARS      = 16;
  localparam int TICK_PERIOD_US = 1000;

  // Field widths
  localparam int RX_BYTE_W = 8;
  localparam int HB_W      = 32;
  localparam int HEIGHT_W  = 36;
  localparam int VEL_W     = 26;
  localparam int OFFSET_W  = 31;
  localparam int DIGIT_W   = 20;

  // Command codes
  localparam logic CMD_IDLE = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Characters of the frame
  localparam logic [RX_BYTE_W-1:0] CHAR_R  = 8'h52;
  localparam logic [RX_BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [RX_BYTE_W-1:0] CHAR_0  = 8'h30;
  localparam logic [RX_BYTE_W-1:0] CHAR_9  = 8'h39;

  // Frame length: start character plus digits, accepted while below this
  localparam int FRAME_CHAR_LIMIT = 8;
  localparam int CC_W             = $clog2(MAX_CHARS);

  // Scaling and limits
  localparam int UM_PER_INCH   = 25400;
  localparam int UM_W          = $clog2(UM_PER_INCH + 1);
  localparam int JUMP_LIMIT_UM = 20000000;
  localparam int US_PER_MS     = 1000;
  localparam int MS_LIMIT      = 500;
  localparam int TIMEOUT_TICKS = (MS_LIMIT * US_PER_MS) / TICK_PERIOD_US;
  // Tick interval bounds that give a time of 1..499 ms
  localparam int MS_MIN_TICKS  = (US_PER_MS + TICK_PERIOD_US - 1) / TICK_PERIOD_US;
  localparam int MS_MAX_TICKS  = (MS_LIMIT * US_PER_MS - 1) / TICK_PERIOD_US;
  localparam int IV_W          = $clog2(MS_MAX_TICKS + 1);
  localparam int P_W           = $clog2(MS_LIMIT * US_PER_MS);

  // Serial divider sizing
  localparam int JUMP_W    = $clog2(JUMP_LIMIT_UM);
  localparam int DVD_W     = (JUMP_W > P_W) ? JUMP_W : P_W;
  localparam int DVS_W     = $clog2(US_PER_MS + 1);
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HGT,
    ST_DIV_MS,
    ST_DIV_VEL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               frame_ok;
    logic [DIGIT_W-1:0] digits;
  } lex_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/srfp_in_if.sv @@
interface srfp_in_if;
  import srfp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [RX_BYTE_W-1:0] rx_byte;
  logic [HB_W-1:0]      heartbeat_count;

  modport source (output valid, command, rx_byte, heartbeat_count, input ready);
  modport sink   (input valid, command, rx_byte, heartbeat_count, output ready);

endinterface

@@ design/srfp_out_if.sv @@
interface srfp_out_if;
  import srfp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_um;
  logic signed [VEL_W-1:0]    velocity_mm_s;
  logic [HB_W-1:0]            sample_ticks;
  logic                       valid_res;

  modport source (output valid, height_um, velocity_mm_s, sample_ticks, valid_res,
                  input ready);
  modport sink   (input valid, height_um, velocity_mm_s, sample_ticks, valid_res,
                  output ready);

endinterface

@@ design/sonar_range_frame_parser_core.sv @@
// Sonar range frame parser.
// Input channel in_i (valid/ready): one control tick per transfer, either idle
// (command 0) or carrying one received serial byte, always with the heartbeat
// count. Output channel out_o (valid/ready): exactly one result per input
// transfer, in order: held height in um minus offset, velocity in mm/s, the
// tick interval between the last two well-formed frames and the valid flag.
// Configuration: cfg_we_i writes cfg_wdata_i into the height offset; write it
// only while no tick is in flight.
// Idle ticks, plain bytes and CRs that are not accepted go through capture,
// execute and emit. A well-formed CR with an interval of 1..499 ms also has
// a height step and runs the bit-serial divider twice, first for the time in
// ms and then for the velocity, one quotient bit per cycle. A jump of 20 m or
// more skips the second pass. One tick is handled at a time; the next is
// taken once the result has moved into the output register.
// Reset clears all frame state, the held results and the offset.
// When the receiver stalls, the result stays in the output register; a new
// tick is still taken and worked on, and waits for the slot before emitting.
module sonar_range_frame_parser_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [srfp_pkg::OFFSET_W-1:0] cfg_wdata_i,
  srfp_in_if.sink                             in_i,
  srfp_out_if.source                          out_o
);
  import srfp_pkg::*;

  localparam logic signed [HEIGHT_W-1:0] JUMP_POS = HEIGHT_W'(JUMP_LIMIT_UM);
  localparam logic signed [HEIGHT_W-1:0] JUMP_NEG = -JUMP_POS;

  state_e state_q, state_d;

  // captured tick
  logic                 cmd_q;
  logic [RX_BYTE_W-1:0] byte_q;
  logic [HB_W-1:0]      hb_q;

  // configuration
  logic signed [OFFSET_W-1:0] offset_q;

  // frame timing and held results
  logic [HB_W-1:0]            last_q, last_d;
  logic [HB_W-1:0]            interval_q, interval_d;
  logic signed [HEIGHT_W-1:0] raw_q, raw_d;
  logic signed [HEIGHT_W-1:0] held_h_q, held_h_d;
  logic signed [VEL_W-1:0]    held_v_q, held_v_d;
  logic                       valid_q, valid_d;

  // working registers
  logic [HEIGHT_W-1:0]        h_q, h_d;
  logic signed [HEIGHT_W-1:0] dh_q, dh_d;
  logic                       jump_ok_q, jump_ok_d;

  // output register
  logic                       out_valid_q;
  logic signed [HEIGHT_W-1:0] out_h_q;
  logic signed [VEL_W-1:0]    out_v_q;
  logic [HB_W-1:0]            out_ticks_q;
  logic                       out_res_q;
  logic                       out_load;

  // sub-units
  lex_stat_t           lex;
  logic                lex_take, lex_clear;
  div_stat_t           div_stat;
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend, div_quo;
  logic [DVS_W-1:0]    div_divisor;

  // datapath helpers
  logic [HB_W-1:0]                 dt;
  logic                            idle_ok, in_range, is_cr;
  logic [DIGIT_W+UM_W-1:0]         h_prod;
  logic [P_W-1:0]                  iv_us;
  logic signed [HEIGHT_W-1:0]      offset_ext, dh_w, dh_abs;
  logic [VEL_W-1:0]                vel_mag;

  srfp_lexer u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (lex_take),
    .clear_i (lex_clear),
    .byte_i  (byte_q),
    .stat_o  (lex)
  );

  srfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // signed tick difference against the last well-formed frame
  assign dt       = hb_q - last_q;
  assign idle_ok  = !dt[HB_W-1] && (dt != '0) && (dt < HB_W'(TIMEOUT_TICKS));
  assign in_range = !dt[HB_W-1] && (dt >= HB_W'(MS_MIN_TICKS)) &&
                    (dt <= HB_W'(MS_MAX_TICKS));
  assign is_cr    = (byte_q == CHAR_CR);

  assign h_prod     = (DIGIT_W+UM_W)'(lex.digits) * (DIGIT_W+UM_W)'(UM_PER_INCH);
  assign iv_us      = P_W'(interval_q[IV_W-1:0]) * P_W'(TICK_PERIOD_US);
  assign offset_ext = {{(HEIGHT_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
  assign dh_w       = $signed(h_q) - raw_q;
  assign dh_abs     = dh_q[HEIGHT_W-1] ? -dh_q : dh_q;
  assign vel_mag    = VEL_W'(div_quo);

  // first pass: interval in us over 1000; second pass: |dh| over ms
  assign div_dividend = (state_q == ST_HGT) ? DVD_W'(iv_us) : dh_abs[DVD_W-1:0];
  assign div_divisor  = (state_q == ST_HGT) ? DVS_W'(US_PER_MS) : div_quo[DVS_W-1:0];

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    interval_d = interval_q;
    raw_d      = raw_q;
    held_h_d   = held_h_q;
    held_v_d   = held_v_q;
    valid_d    = valid_q;
    h_d        = h_q;
    dh_d       = dh_q;
    jump_ok_d  = jump_ok_q;
    lex_take   = 1'b0;
    lex_clear  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_EMIT;
        if (cmd_q == CMD_BYTE) begin
          if (is_cr) begin
            // end of frame: always drop the partial frame
            lex_clear = 1'b1;
            valid_d   = 1'b0;
            if (lex.frame_ok) begin
              interval_d = dt;
              last_d     = hb_q;
              if (in_range) begin
                valid_d = 1'b1;
                h_d     = HEIGHT_W'(h_prod);
                state_d = ST_HGT;
              end
            end
          end else begin
            lex_take = 1'b1;
          end
        end else begin
          // idle tick: time out stale data
          valid_d = idle_ok;
          if (!idle_ok) begin
            held_h_d   = '0;
            held_v_d   = '0;
            interval_d = '0;
          end
        end
      end
      ST_HGT: begin
        dh_d      = dh_w;
        raw_d     = $signed(h_q);
        held_h_d  = $signed(h_q) - offset_ext;
        jump_ok_d = (dh_w < JUMP_POS) && (dh_w > JUMP_NEG);
        div_start = 1'b1;
        state_d   = ST_DIV_MS;
      end
      ST_DIV_MS: begin
        if (div_stat.done) begin
          if (jump_ok_q) begin
            div_start = 1'b1;
            state_d   = ST_DIV_VEL;
          end else begin
            held_v_d = '0;
            state_d  = ST_EMIT;
          end
        end
      end
      ST_DIV_VEL: begin
        if (div_stat.done) begin
          // truncate toward zero: divide the magnitude, restore the sign
          held_v_d = dh_q[HEIGHT_W-1] ? $signed(-vel_mag) : $signed(vel_mag);
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= '0;
      last_q      <= '0;
      interval_q  <= '0;
      raw_q       <= '0;
      held_h_q    <= '0;
      held_v_q    <= '0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      interval_q  <= interval_d;
      raw_q       <= raw_d;
      held_h_q    <= held_h_d;
      held_v_q    <= held_v_d;
      valid_q     <= valid_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      byte_q <= in_i.rx_byte;
      hb_q   <= in_i.heartbeat_count;
    end
    h_q       <= h_d;
    dh_q      <= dh_d;
    jump_ok_q <= jump_ok_d;
    if (out_load) begin
      out_h_q     <= held_h_q;
      out_v_q     <= held_v_q;
      out_ticks_q <= interval_q;
      out_res_q   <= valid_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.height_um     = out_h_q;
  assign out_o.velocity_mm_s = out_v_q;
  assign out_o.sample_ticks  = out_ticks_q;
  assign out_o.valid_res     = out_res_q;

  // The divider is never left running while a new tick can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_stat.busy)
    else $error("divider busy while idle");

  // Divider completion only lands in a state that waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV_MS || state_q == ST_DIV_VEL))
    else $error("divider completion outside a divide state");

  // Time in ms from the first pass lies in 1..499
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.done && state_q == ST_DIV_MS) |->
      (div_quo != '0 && div_quo < DVD_W'(MS_LIMIT)))
    else $error("frame time out of range");

  // An accepted tick is executed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_EXEC))
    else $error("accepted tick not executed");

endmodule

@@ design/srfp_lexer.sv @@
module srfp_lexer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic                           clear_i,
  input  logic [srfp_pkg::RX_BYTE_W-1:0] byte_i,
  output srfp_pkg::lex_stat_t            stat_o
);
  import srfp_pkg::*;

  logic               got_q, got_d;
  logic               ended_q, ended_d;
  logic [CC_W-1:0]    cc_q, cc_d;
  logic [DIGIT_W-1:0] dv_q, dv_d;
  logic               start;
  logic               is_digit;
  logic [CC_W:0]      cc_inc;
  logic [RX_BYTE_W-1:0] digit;
  logic [DIGIT_W+2:0] acc;

  assign start    = (cc_q == '0) && (byte_i == CHAR_R);
  assign is_digit = (byte_i >= CHAR_0) && (byte_i <= CHAR_9);
  assign digit    = byte_i - CHAR_0;
  assign cc_inc   = {1'b0, cc_q} + (CC_W+1)'(1);
  // value * 10 + digit, wrapped to the digit width
  assign acc      = {dv_q, 3'b000} + {2'b00, dv_q, 1'b0} + (DIGIT_W+3)'(digit[3:0]);

  always_comb begin
    got_d   = got_q;
    ended_d = ended_q;
    cc_d    = cc_q;
    dv_d    = dv_q;
    if (clear_i) begin
      got_d = 1'b0;
      cc_d  = '0;
    end else if (take_i && (got_q || start)) begin
      got_d = 1'b1;
      if (cc_q == '0) begin
        dv_d    = '0;
        ended_d = 1'b0;
      end else if (!ended_q && is_digit) begin
        dv_d = acc[DIGIT_W-1:0];
      end else begin
        ended_d = 1'b1;
      end
      // wrap on overflow, keep the start flag
      cc_d = (cc_inc == (CC_W+1)'(MAX_CHARS)) ? '0 : cc_inc[CC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      got_q   <= 1'b0;
      ended_q <= 1'b0;
      cc_q    <= '0;
      dv_q    <= '0;
    end else begin
      got_q   <= got_d;
      ended_q <= ended_d;
      cc_q    <= cc_d;
      dv_q    <= dv_d;
    end
  end

  assign stat_o.frame_ok = got_q && (cc_q > CC_W'(1)) &&
                           ({1'b0, cc_q} < (CC_W+1)'(FRAME_CHAR_LIMIT));
  assign stat_o.digits   = dv_q;

endmodule

@@ design/srfp_div.sv @@
module srfp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [srfp_pkg::DVD_W-1:0] dividend_i,
  input  logic [srfp_pkg::DVS_W-1:0] divisor_i,
  output srfp_pkg::div_stat_t        stat_o,
  output logic [srfp_pkg::DVD_W-1:0] quotient_o
);
  import srfp_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q, dvs_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DVS_W:0]       rem_sh, diff;
  logic                 fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
      busy_q <= (cnt_q != DIV_CNT_W'(1));
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import srfp_pkg::*;

  // Quiet cycles to let a worst-case CR finish (two divider passes plus margin)
  localparam int DRAIN_CYCLES = 2 * DVD_W + 16;
  // Cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_TICKS  = 300;

  typedef struct {
    logic                 command;
    logic [RX_BYTE_W-1:0] rx_byte;
    logic [HB_W-1:0]      heartbeat;
  } tick_t;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height_um;
    logic signed [VEL_W-1:0]    velocity_mm_s;
    logic [HB_W-1:0]            sample_ticks;
    logic                       valid_res;
  } range_report_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic signed [OFFSET_W-1:0] cfg_wdata_i;

  srfp_in_if  tick_if ();
  srfp_out_if report_if ();

  sonar_range_frame_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_if),
    .out_o       (report_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: frame state, held results and the offset, kept at the
  // block's widths and advanced once per accepted tick.
  // ---------------------------------------------------------------------------
  longint                    m_offset;
  int unsigned               m_char_count;
  bit                        m_got_start;
  logic [DIGIT_W-1:0]        m_digits;
  bit                        m_digits_ended;
  logic [HB_W-1:0]           m_last_frame;
  logic [HB_W-1:0]           m_interval;
  longint                    m_raw_height;
  longint                    m_held_height;
  longint                    m_held_velocity;
  bit                        m_valid;

  // Run statistics for the closing summary
  int n_accepted_frames;
  int n_moving_frames;
  int n_timeouts;
  int n_ticks_sent;
  int n_reports_seen;
  int err_count;

  function automatic range_report_t predict_range_report(tick_t t);
    range_report_t rep;
    longint        ms;
    longint        h;
    longint        dh;
    longint        dt;
    logic [HB_W-1:0] diff;
    bit            ok;
    ok = 1'b0;
    if (t.command == CMD_BYTE) begin
      if (t.rx_byte == CHAR_CR) begin
        // Close the frame; only a well-formed one moves the frame time
        if (m_got_start && m_char_count > 1 && m_char_count < FRAME_CHAR_LIMIT) begin
          m_interval   = t.heartbeat - m_last_frame;
          m_last_frame = t.heartbeat;
          ms = longint'($signed(m_interval)) * TICK_PERIOD_US / US_PER_MS;
          if (ms > 0 && ms < MS_LIMIT) begin
            h  = longint'(m_digits) * UM_PER_INCH;
            dh = h - m_raw_height;
            m_raw_height  = h;
            m_held_height = h - m_offset;
            if (dh < JUMP_LIMIT_UM && dh > -JUMP_LIMIT_UM)
              m_held_velocity = dh / ms;
            else
              m_held_velocity = 0;
            ok = 1'b1;
            n_accepted_frames++;
            if (m_held_velocity != 0) n_moving_frames++;
          end
        end
        m_valid      = ok;
        m_got_start  = 1'b0;
        m_char_count = 0;
      end else begin
        if (m_char_count == 0 && t.rx_byte == CHAR_R) m_got_start = 1'b1;
        if (m_got_start) begin
          if (m_char_count == 0) begin
            m_digits       = '0;
            m_digits_ended = 1'b0;
          end else if (!m_digits_ended && t.rx_byte >= CHAR_0 && t.rx_byte <= CHAR_9) begin
            m_digits = DIGIT_W'(m_digits * 10 + (t.rx_byte - CHAR_0));
          end else begin
            m_digits_ended = 1'b1;
          end
          m_char_count++;
          if (m_char_count >= MAX_CHARS) m_char_count = 0;
        end
      end
    end else begin
      // Idle tick: hold the reading while the last frame is recent, else clear it
      diff    = t.heartbeat - m_last_frame;
      dt      = longint'($signed(diff));
      m_valid = dt > 0 && dt < TIMEOUT_TICKS;
      if (!m_valid) begin
        m_held_velocity = 0;
        m_held_height   = 0;
        m_interval      = '0;
        n_timeouts++;
      end
    end
    rep.height_um     = m_held_height[HEIGHT_W-1:0];
    rep.velocity_mm_s = m_held_velocity[VEL_W-1:0];
    rep.sample_ticks  = m_interval;
    rep.valid_res     = m_valid;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: present queued ticks with random gaps, mirror each transfer.
  // ---------------------------------------------------------------------------
  tick_t         pending_ticks[$];
  range_report_t reports_due[$];
  tick_t         cur_tick;
  bit            tx_busy;
  bit            tx_burst;
  bit            rx_burst;
  int            tx_gap;
  int            rx_stall;
  int            quiet_cycles;

  // Mostly short gaps, now and then a long one; none at all in a burst
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst)  return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid           <= 1'b0;
      tick_if.command         <= CMD_IDLE;
      tick_if.rx_byte         <= '0;
      tick_if.heartbeat_count <= '0;
      tx_busy = 1'b0;
      tx_gap  = 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        reports_due.push_back(predict_range_report(cur_tick));
        n_ticks_sent++;
        tx_busy = 1'b0;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        tx_gap = pick_gap(tx_burst);
      end
      // Advance to the next tick once the gap has run out
      if (!tx_busy) begin
        if (tx_gap > 0)
          tx_gap--;
        else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          tx_busy  = 1'b1;
        end
      end
      tick_if.valid           <= tx_busy;
      tick_if.command         <= cur_tick.command;
      tick_if.rx_byte         <= cur_tick.rx_byte;
      tick_if.heartbeat_count <= cur_tick.heartbeat;
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: stall at random, check each transfer against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  range_report_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (report_if.valid && report_if.ready) begin
        n_reports_seen++;
        if (reports_due.size() == 0) begin
          $error("range report arrived with no tick waiting for it");
          err_count++;
        end else begin
          want = reports_due.pop_front();
          if (report_if.height_um !== want.height_um) begin
            $error("height_um: expected %0d, got %0d", want.height_um, report_if.height_um);
            err_count++;
          end
          if (report_if.velocity_mm_s !== want.velocity_mm_s) begin
            $error("velocity_mm_s: expected %0d, got %0d",
                   want.velocity_mm_s, report_if.velocity_mm_s);
            err_count++;
          end
          if (report_if.sample_ticks !== want.sample_ticks) begin
            $error("sample_ticks: expected %0d, got %0d",
                   want.sample_ticks, report_if.sample_ticks);
            err_count++;
          end
          if (report_if.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0b, got %0b", want.valid_res, report_if.valid_res);
            err_count++;
          end
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_stall = pick_gap(rx_burst);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        report_if.ready <= 1'b0;
      end else begin
        report_if.ready <= 1'b1;
      end
    end
  end

  // Abandon the run when neither channel has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (report_if.valid && report_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d reports outstanding",
                 quiet_cycles, reports_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: the generator keeps its own notion of the last well-formed
  // frame time so that intervals and idle ticks land around the limits.
  // ---------------------------------------------------------------------------
  logic [HB_W-1:0] gen_last;
  int              gen_inches;
  int              n_queued;

  task automatic push_tick(input logic cmd, input logic [RX_BYTE_W-1:0] b,
                           input logic [HB_W-1:0] hb);
    tick_t t;
    t.command   = cmd;
    t.rx_byte   = b;
    t.heartbeat = hb;
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  function automatic logic [RX_BYTE_W-1:0] non_cr_byte();
    logic [RX_BYTE_W-1:0] b;
    b = CHAR_CR;
    while (b == CHAR_CR) b = RX_BYTE_W'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [RX_BYTE_W-1:0] non_digit_byte();
    logic [RX_BYTE_W-1:0] b;
    b = CHAR_CR;
    while (b == CHAR_CR || (b >= CHAR_0 && b <= CHAR_9))
      b = RX_BYTE_W'($urandom_range(0, 255));
    return b;
  endfunction

  // Interval to the next CR: mostly inside the window, the rest on and past its edges
  function automatic int pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, MS_LIMIT - 1);
    if (r < 75) return 0;
    if (r < 80) return $urandom_range(MS_LIMIT - 1, MS_LIMIT);
    if (r < 88) return $urandom_range(MS_LIMIT + 1, 5000);
    if (r < 94) return -int'($urandom_range(1, 1000));
    return $urandom;
  endfunction

  // Heartbeat for an idle tick, spread around the timeout boundary
  function automatic logic [HB_W-1:0] idle_hb();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return gen_last - $urandom_range(0, 3);
    if (r < 75) return gen_last + $urandom_range(1, TIMEOUT_TICKS - 1);
    if (r < 85) return gen_last + $urandom_range(TIMEOUT_TICKS - 2, TIMEOUT_TICKS + 1);
    if (r < 95) return gen_last + $urandom_range(TIMEOUT_TICKS + 2, 5000);
    return $urandom;
  endfunction

  function automatic int digit_len(int v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // Lead byte, nd digits of the value (zero padded), CR; with mix set, drop
  // in idle ticks and now and then a stray non-digit
  task automatic push_frame(input logic [RX_BYTE_W-1:0] lead, input int unsigned value,
                            input int nd, input logic [HB_W-1:0] cr_hb, input bit mix);
    logic [RX_BYTE_W-1:0] digs[$];
    int unsigned          v;
    int                   k;
    v = value;
    for (k = 0; k < nd; k++) begin
      digs.push_front(CHAR_0 + RX_BYTE_W'(v % 10));
      v = v / 10;
    end
    if (mix && nd > 0 && $urandom_range(0, 9) == 0)
      digs[$urandom_range(0, nd - 1)] = non_digit_byte();
    push_tick(CMD_BYTE, lead, $urandom);
    for (k = 0; k < nd; k++) begin
      if (mix && $urandom_range(0, 9) == 0)
        push_tick(CMD_IDLE, RX_BYTE_W'($urandom), idle_hb());
      push_tick(CMD_BYTE, digs[k], $urandom);
    end
    push_tick(CMD_BYTE, CHAR_CR, cr_hb);
    if (nd >= 1 && nd <= 6) gen_last = cr_hb;
    if (mix && $urandom_range(0, 2) == 0)
      push_tick(CMD_IDLE, RX_BYTE_W'($urandom), idle_hb());
  endtask

  // Walk the range in small steps so that most jumps stay under the limit
  task automatic walk_range();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      gen_inches = gen_inches + int'($urandom_range(0, 1600)) - 800;
    else if (r < 90)
      gen_inches = $urandom_range(0, 999999);
    else
      gen_inches = ($urandom_range(0, 1) != 0) ? 999999 : 0;
    if (gen_inches < 0)      gen_inches = 0;
    if (gen_inches > 999999) gen_inches = 999999;
  endtask

  task automatic random_episode();
    int r;
    int n;
    int nd;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      walk_range();
      nd = digit_len(gen_inches);
      nd = nd + $urandom_range(0, 6 - nd);
      push_frame(CHAR_R, gen_inches, nd, gen_last + pick_interval(), 1'b1);
    end else if (r < 82) begin
      n = $urandom_range(1, 6);
      repeat (n) push_tick(CMD_IDLE, RX_BYTE_W'($urandom), idle_hb());
    end else if (r < 90) begin
      // Wrong length: start character alone, or too many digits
      nd = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(7, 14);
      push_frame(CHAR_R, $urandom, nd, gen_last + pick_interval(), 1'b1);
    end else if (r < 96) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        r = $urandom_range(0, 3);
        push_tick(1'($urandom_range(0, 1)),
                  (r == 0) ? CHAR_CR : (r == 1) ? CHAR_R : 8'($urandom_range(0, 255)),
                  ($urandom_range(0, 1) != 0) ? idle_hb() : $urandom);
      end
    end else begin
      // Overrun the buffer: the count wraps and the next byte becomes the lead
      push_tick(CMD_BYTE, CHAR_R, $urandom);
      repeat (MAX_CHARS - 1) push_tick(CMD_BYTE, non_cr_byte(), $urandom);
      walk_range();
      nd = $urandom_range(1, 6);
      push_frame(non_cr_byte(), gen_inches, nd, gen_last + pick_interval(), 1'b0);
    end
  endtask

  task automatic fill_random(input int count);
    int target;
    target = n_queued + count;
    while (n_queued < target) random_episode();
  endtask

  // Hold the sender until every report is back, let the block settle, then
  // write the offset
  task automatic apply_offset(input int value);
    while (pending_ticks.size() != 0 || tx_busy || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= OFFSET_W'(value);
    m_offset     = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = '0;
    tick_if.valid           = 1'b0;
    tick_if.command         = CMD_IDLE;
    tick_if.rx_byte         = '0;
    tick_if.heartbeat_count = '0;
    report_if.ready         = 1'b0;
    cur_tick                = '{CMD_IDLE, '0, '0};
    tx_burst                = 1'b0;
    rx_burst                = 1'b0;
    quiet_cycles            = 0;

    m_offset          = 0;
    m_char_count      = 0;
    m_got_start       = 1'b0;
    m_digits          = '0;
    m_digits_ended    = 1'b0;
    m_last_frame      = '0;
    m_interval        = '0;
    m_raw_height      = 0;
    m_held_height     = 0;
    m_held_velocity   = 0;
    m_valid           = 1'b0;
    n_accepted_frames = 0;
    n_moving_frames   = 0;
    n_timeouts        = 0;
    n_ticks_sent      = 0;
    n_reports_seen    = 0;
    err_count         = 0;
    n_queued          = 0;
    gen_last          = '0;
    gen_inches        = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening, offset still at its reset value
    push_tick(CMD_IDLE, 8'hFF, 32'd0);                   // no frame yet: times out at once
    push_frame(CHAR_R, 12, 2, 32'd1, 1'b0);              // shortest interval, small jump
    push_tick(CMD_IDLE, 8'h00, 32'd1 + TIMEOUT_TICKS - 1); // last tick still recent
    push_tick(CMD_IDLE, 8'h5A, 32'd1 + TIMEOUT_TICKS);     // first stale tick clears
    push_frame(CHAR_R, 999999, 6, 32'd500, 1'b0);        // longest interval, jump too large
    push_frame(CHAR_R, 0, 0, 32'd501, 1'b0);             // start character alone
    push_frame(CHAR_R, 5, 1, 32'd1000, 1'b0);            // interval of 500 ms is rejected
    push_tick(CMD_BYTE, CHAR_R, 32'd0);                  // digits end at a letter
    push_tick(CMD_BYTE, 8'h41, 32'd0);
    push_tick(CMD_BYTE, CHAR_0 + RX_BYTE_W'(7), 32'd0);
    push_tick(CMD_BYTE, CHAR_CR, 32'd1001);
    push_frame(CHAR_R, 3, 1, 32'd1011, 1'b0);            // small rise after a reset height
    gen_last   = 32'd1011;
    gen_inches = 3;

    fill_random(PHASE_TICKS);
    apply_offset(-1000000000);
    fill_random(PHASE_TICKS);
    apply_offset(1000000000);
    fill_random(PHASE_TICKS);
    apply_offset(int'($urandom_range(0, 2000000000)) - 1000000000);
    fill_random(PHASE_TICKS);
    apply_offset(-int'($urandom_range(1, 60000)));
    fill_random(PHASE_TICKS);
    apply_offset(0);
    fill_random(PHASE_TICKS);

    // Drain, then give the block time to show any stray report
    while (pending_ticks.size() != 0 || tx_busy || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks under 6 offsets, checked %0d reports", n_ticks_sent, n_reports_seen);
    $display("Frames accepted %0d (%0d with nonzero velocity), timeout clears %0d",
             n_accepted_frames, n_moving_frames, n_timeouts);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
